### rtl/humidity_tick_conversion_assert.svh
// Assertion macros shared by the humidity conversion RTL.
`ifndef HUMIDITY_TICK_CONVERSION_ASSERT_SVH
`define HUMIDITY_TICK_CONVERSION_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define HTC_ASSERT_HOLD(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define HTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HTC_ASSERT_HOLD(label, ante, cons, msg)
`define HTC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/htc_pkg.sv
// Types, widths and constants of the humidity/temperature conversion pipeline.
`default_nettype none

package htc_pkg;

    // Port field widths
    localparam int REG_W     = 40;
    localparam int RH_W      = 12;
    localparam int TK_W      = 14;
    localparam int TC_W      = 16;
    localparam int HC_W      = 14;
    localparam int FLAG_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    localparam int FRAC_BITS_DEF = 32;

    // Internal datapath widths, sized for any fraction width up to 40
    localparam int T_W    = 55;               // temperature, fixed point
    localparam int LSQ_W  = 53;               // lin_square * rh
    localparam int LIN_W  = 53;               // lin_linear * rh + lin_const
    localparam int F_W    = 53;               // compensation factor
    localparam int DT_W   = 56;               // T - 25
    localparam int RL_W   = 64;               // linearized / compensated humidity
    localparam int T100_W = 64;               // T * 100 + half
    localparam int RND_W  = 72;               // H * 100 + half, H * 10

    // Split of the DT x factor product into four partial products
    localparam int DL_W  = 28;
    localparam int FL_W  = 27;
    localparam int DH_W  = DT_W - DL_W;
    localparam int FH_W  = F_W - FL_W;
    localparam int PLL_W = DL_W + FL_W;
    localparam int PHH_W = DH_W + FH_W;
    localparam int PHL_W = DH_W + FL_W + 1;
    localparam int PLH_W = DL_W + 1 + FH_W;
    localparam int PS_W  = PHL_W + DL_W + 1;
    localparam int P_W   = DT_W + F_W;

    // Scale constants
    localparam int TEMP_BIAS_C = 25;
    localparam int PCT_MAX     = 100;
    localparam int CENTI       = 100;
    localparam int DECI        = 10;

    localparam logic [HC_W-1:0]        HCENT_MAX = 14'd10000;
    localparam logic [HC_W-1:0]        HCENT_MIN = 14'd10;
    localparam logic signed [TC_W-1:0] TCENT_MAX = 16'sh7FFF;
    localparam logic signed [TC_W-1:0] TCENT_MIN = 16'sh8000;
    localparam logic signed [RL_W-1:0] SAT_MAX   = {1'b0, {(RL_W-1){1'b1}}};
    localparam logic signed [RL_W-1:0] SAT_MIN   = {1'b1, {(RL_W-1){1'b0}}};

    // Clamp flag codes
    localparam logic [FLAG_W-1:0] FLAG_OK   = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_HIGH = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_LOW  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIN_CONST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIN_LINEAR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIN_SQUARE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COMP_BASE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COMP_SLOPE  = 3'd6;

    typedef struct packed {
        logic signed [REG_W-1:0] temp_offset;
        logic signed [REG_W-1:0] temp_slope;
        logic signed [REG_W-1:0] lin_const;
        logic signed [REG_W-1:0] lin_linear;
        logic signed [REG_W-1:0] lin_square;
        logic signed [REG_W-1:0] comp_base;
        logic signed [REG_W-1:0] comp_slope;
    } t_coef;

    localparam t_coef COEF_RST = '{
        temp_offset: -40'sd172228188570,
        temp_slope:  40'sd42949673,
        lin_const:   -40'sd8790939061,
        lin_linear:  40'sd157625300,
        lin_square:  -40'sd6853,
        comp_base:   40'sd42949673,
        comp_slope:  40'sd343597
    };

    // Front end -> compensation multiplier
    typedef struct packed {
        logic signed [DT_W-1:0]   dt;
        logic signed [F_W-1:0]    factor;
        logic signed [RL_W-1:0]   rh_lin;
        logic signed [T100_W-1:0] t100;
    } t_front;

    // Compensation multiplier -> output stages
    typedef struct packed {
        logic signed [RL_W-1:0] comp;
        logic signed [RL_W-1:0] rh_lin;
        logic signed [TC_W-1:0] tcent;
    } t_mid;

endpackage

`default_nettype wire

### rtl/htc_cfg.sv
// Coefficient register file with write channel.
`default_nettype none
`include "humidity_tick_conversion_assert.svh"

module htc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [htc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [htc_pkg::REG_W-1:0]     i_cfg_data,
    output htc_pkg::t_coef                o_coef
);
    import htc_pkg::*;

    t_coef r_coef;
    t_coef n_coef;

    assign o_cfg_ready = 1'b1;
    assign o_coef      = r_coef;

    always_comb begin
        n_coef = r_coef;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TEMP_OFFSET: n_coef.temp_offset = i_cfg_data;
                REG_TEMP_SLOPE:  n_coef.temp_slope  = i_cfg_data;
                REG_LIN_CONST:   n_coef.lin_const   = i_cfg_data;
                REG_LIN_LINEAR:  n_coef.lin_linear  = i_cfg_data;
                REG_LIN_SQUARE:  n_coef.lin_square  = i_cfg_data;
                REG_COMP_BASE:   n_coef.comp_base   = i_cfg_data;
                REG_COMP_SLOPE:  n_coef.comp_slope  = i_cfg_data;
                default: ;  // drop writes past the last register
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= COEF_RST;
        end else begin
            r_coef <= n_coef;
        end
    end

    `HTC_ASSERT_NEXT(a_cfg_square_write, i_cfg_valid && o_cfg_ready && (i_cfg_index == REG_LIN_SQUARE), r_coef.lin_square == $past(i_cfg_data), "lin_square write not stored")
    `HTC_ASSERT_NEXT(a_cfg_bad_index, i_cfg_valid && (i_cfg_index > REG_COMP_SLOPE), $stable(r_coef), "write past last register changed a coefficient")

endmodule

`default_nettype wire

### rtl/htc_front.sv
// Front stages: tick products, temperature, linearization, T*100 and T-25.
`default_nettype none

module htc_front #(
    parameter int FRAC_BITS = htc_pkg::FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  htc_pkg::t_coef           i_coef,
    input  logic                     i_vld,
    output logic                     o_rdy,
    input  logic [htc_pkg::RH_W-1:0] i_rh,
    input  logic [htc_pkg::TK_W-1:0] i_tk,
    output logic                     o_vld,
    input  logic                     i_rdy,
    output htc_pkg::t_front          o_data
);
    import htc_pkg::*;

    localparam int NS    = 3;
    localparam int SQF_W = LSQ_W + RH_W + 1;
    localparam logic signed [DT_W-1:0]   TBIAS   = DT_W'(TEMP_BIAS_C) <<< FRAC_BITS;
    localparam logic signed [T100_W-1:0] HALF    = T100_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [T100_W-1:0] CENTI_K = T100_W'(CENTI);

    // Stage handshake: a stage loads when empty or when its successor loads
    logic [NS-1:0] r_vld;
    logic [NS:0]   w_rdy;

    always_comb begin
        w_rdy[NS] = i_rdy;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_rdy  = w_rdy[0];
    assign o_vld  = r_vld[NS-1];

    // Stage 1: products with the raw ticks
    logic signed [T_W-1:0]   n1_tprod, r1_tprod;
    logic signed [LSQ_W-1:0] n1_lsq,   r1_lsq;
    logic signed [LIN_W-1:0] n1_llin,  r1_llin;
    logic signed [F_W-1:0]   n1_fprod, r1_fprod;
    logic [RH_W-1:0]         r1_rh;

    assign n1_tprod = T_W'(i_coef.temp_slope) * T_W'($signed({1'b0, i_tk}));
    assign n1_lsq   = LSQ_W'(i_coef.lin_square) * LSQ_W'($signed({1'b0, i_rh}));
    assign n1_llin  = LIN_W'(i_coef.lin_linear) * LIN_W'($signed({1'b0, i_rh}));
    assign n1_fprod = F_W'(i_coef.comp_slope) * F_W'($signed({1'b0, i_rh}));

    // Stage 2: temperature, square term, factor, linear plus constant
    logic signed [T_W-1:0]   n2_tc,     r2_tc;
    logic signed [SQF_W-1:0] w_sq_full;
    logic signed [RL_W-1:0]  n2_sq,     r2_sq;
    logic signed [F_W-1:0]   n2_factor, r2_factor;
    logic signed [LIN_W-1:0] n2_lin1,   r2_lin1;

    assign n2_tc     = T_W'(i_coef.temp_offset) + r1_tprod;
    assign w_sq_full = SQF_W'(r1_lsq) * SQF_W'($signed({1'b0, r1_rh}));
    assign n2_sq     = w_sq_full[RL_W-1:0];
    assign n2_factor = F_W'(i_coef.comp_base) + r1_fprod;
    assign n2_lin1   = LIN_W'(i_coef.lin_const) + r1_llin;

    // Stage 3: linearized humidity, T - 25, T*100 with rounding half
    t_front n3_data, r3_data;

    assign n3_data.rh_lin = r2_sq + RL_W'(r2_lin1);
    assign n3_data.dt     = DT_W'(r2_tc) - TBIAS;
    assign n3_data.factor = r2_factor;
    assign n3_data.t100   = T100_W'(r2_tc) * CENTI_K + HALF;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_tprod <= n1_tprod;
            r1_lsq   <= n1_lsq;
            r1_llin  <= n1_llin;
            r1_fprod <= n1_fprod;
            r1_rh    <= i_rh;
        end
        if (w_rdy[1]) begin
            r2_tc     <= n2_tc;
            r2_sq     <= n2_sq;
            r2_factor <= n2_factor;
            r2_lin1   <= n2_lin1;
        end
        if (w_rdy[2]) begin
            r3_data <= n3_data;
        end
    end

    assign o_data = r3_data;

endmodule

`default_nettype wire

### rtl/htc_mul.sv
// Compensation product (T-25)*factor in partial products, floor and saturate; also clamps temperature hundredths.
`default_nettype none

module htc_mul #(
    parameter int FRAC_BITS = htc_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    output logic            o_rdy,
    input  htc_pkg::t_front i_data,
    output logic            o_vld,
    input  logic            i_rdy,
    output htc_pkg::t_mid   o_data
);
    import htc_pkg::*;

    localparam int NS = 4;

    typedef struct packed {
        logic signed [RL_W-1:0] rh_lin;
        logic signed [TC_W-1:0] tcent;
    } t_side;

    logic [NS-1:0] r_vld;
    logic [NS:0]   w_rdy;

    always_comb begin
        w_rdy[NS] = i_rdy;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_rdy = w_rdy[0];
    assign o_vld = r_vld[NS-1];

    // Stage 4: four partial products; temperature rounding and clamp
    logic [DL_W-1:0]          w_dl;
    logic signed [DH_W-1:0]   w_dh;
    logic [FL_W-1:0]          w_fl;
    logic signed [FH_W-1:0]   w_fh;
    logic [PLL_W-1:0]         n4_pll, r4_pll;
    logic signed [PHH_W-1:0]  n4_phh, r4_phh;
    logic signed [PHL_W-1:0]  n4_phl, r4_phl;
    logic signed [PLH_W-1:0]  n4_plh, r4_plh;
    logic signed [T100_W-1:0] w_tsh;
    t_side                    n4_side, r4_side;

    assign w_dl = i_data.dt[DL_W-1:0];
    assign w_dh = i_data.dt[DT_W-1:DL_W];
    assign w_fl = i_data.factor[FL_W-1:0];
    assign w_fh = i_data.factor[F_W-1:FL_W];

    assign n4_pll = PLL_W'(w_dl) * PLL_W'(w_fl);
    assign n4_phh = PHH_W'(w_dh) * PHH_W'(w_fh);
    assign n4_phl = PHL_W'(w_dh) * PHL_W'($signed({1'b0, w_fl}));
    assign n4_plh = PLH_W'($signed({1'b0, w_dl})) * PLH_W'(w_fh);

    assign w_tsh = i_data.t100 >>> FRAC_BITS;

    always_comb begin
        n4_side.rh_lin = i_data.rh_lin;
        if (w_tsh > T100_W'(TCENT_MAX)) begin
            n4_side.tcent = TCENT_MAX;
        end else if (w_tsh < T100_W'(TCENT_MIN)) begin
            n4_side.tcent = TCENT_MIN;
        end else begin
            n4_side.tcent = w_tsh[TC_W-1:0];
        end
    end

    // Stage 5: outer products concatenate, cross products add
    logic signed [P_W-1:0]  n5_a, r5_a;
    logic signed [PS_W-1:0] n5_b, r5_b;
    t_side                  r5_side;

    assign n5_a = {r4_phh, r4_pll};
    assign n5_b = (PS_W'(r4_phl) <<< DL_W) + (PS_W'(r4_plh) <<< FL_W);

    // Stage 6: full product
    logic signed [P_W-1:0] n6_prod, r6_prod;
    t_side                 r6_side;

    assign n6_prod = r5_a + P_W'(r5_b);

    // Stage 7: floor to fraction bits, saturate to 64 bits
    logic signed [P_W-1:0]   w_sh;
    logic [P_W-RL_W:0]       w_top;
    logic signed [RL_W-1:0]  n7_comp;
    t_mid                    r7_data;

    assign w_sh  = r6_prod >>> FRAC_BITS;
    assign w_top = w_sh[P_W-1:RL_W-1];

    always_comb begin
        if ((&w_top) || !(|w_top)) begin
            n7_comp = w_sh[RL_W-1:0];
        end else if (w_top[P_W-RL_W]) begin
            n7_comp = SAT_MIN;
        end else begin
            n7_comp = SAT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r4_pll  <= n4_pll;
            r4_phh  <= n4_phh;
            r4_phl  <= n4_phl;
            r4_plh  <= n4_plh;
            r4_side <= n4_side;
        end
        if (w_rdy[1]) begin
            r5_a    <= n5_a;
            r5_b    <= n5_b;
            r5_side <= r4_side;
        end
        if (w_rdy[2]) begin
            r6_prod <= n6_prod;
            r6_side <= r5_side;
        end
        if (w_rdy[3]) begin
            r7_data.comp   <= n7_comp;
            r7_data.rh_lin <= r6_side.rh_lin;
            r7_data.tcent  <= r6_side.tcent;
        end
    end

    assign o_data = r7_data;

endmodule

`default_nettype wire

### rtl/htc_out.sv
// Output stages: compensated humidity, clamp decision, rounding, output register.
`default_nettype none

module htc_out #(
    parameter int FRAC_BITS = htc_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    output logic                              o_rdy,
    input  htc_pkg::t_mid                     i_data,
    output logic                              o_vld,
    input  logic                              i_rdy,
    output logic signed [htc_pkg::TC_W-1:0]   o_tcent,
    output logic [htc_pkg::HC_W-1:0]          o_hcent,
    output logic [htc_pkg::FLAG_W-1:0]        o_flag
);
    import htc_pkg::*;

    localparam int NS    = 3;
    localparam int SUM_W = RL_W + 1;
    localparam logic signed [RL_W-1:0]  HUNDRED = RL_W'(PCT_MAX) <<< FRAC_BITS;
    localparam logic signed [RND_W-1:0] ONE_K   = RND_W'(1) <<< FRAC_BITS;
    localparam logic signed [RND_W-1:0] HALF    = RND_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [RND_W-1:0] TEN_K   = RND_W'(DECI);
    localparam logic signed [RND_W-1:0] CENTI_K = RND_W'(CENTI);

    logic [NS-1:0] r_vld;
    logic [NS:0]   w_rdy;

    always_comb begin
        w_rdy[NS] = i_rdy;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_rdy = w_rdy[0];
    assign o_vld = r_vld[NS-1];

    // Stage 8: saturating add of compensation and linearized humidity
    logic signed [SUM_W-1:0] w_sum;
    logic signed [RL_W-1:0]  n8_h, r8_h;
    logic signed [TC_W-1:0]  r8_tcent;

    assign w_sum = SUM_W'(i_data.comp) + SUM_W'(i_data.rh_lin);

    always_comb begin
        if (w_sum[SUM_W-1] == w_sum[RL_W-1]) begin
            n8_h = w_sum[RL_W-1:0];
        end else if (w_sum[SUM_W-1]) begin
            n8_h = SAT_MIN;
        end else begin
            n8_h = SAT_MAX;
        end
    end

    // Stage 9: range compares and rounded hundredths
    logic signed [RND_W-1:0] w_h10;
    logic signed [RND_W-1:0] w_rnd;
    logic                    n9_gt, r9_gt;
    logic                    n9_lo, r9_lo;
    logic [HC_W-1:0]         n9_hc, r9_hc;
    logic signed [TC_W-1:0]  r9_tcent;

    assign w_h10 = RND_W'(r8_h) * TEN_K;
    assign w_rnd = RND_W'(r8_h) * CENTI_K + HALF;
    assign n9_gt = r8_h > HUNDRED;
    assign n9_lo = r8_h[RL_W-1] || (w_h10 < ONE_K);
    assign n9_hc = w_rnd[FRAC_BITS +: HC_W];

    // Stage 10: output register
    logic [HC_W-1:0]        n10_hc,   r10_hc;
    logic [FLAG_W-1:0]      n10_flag, r10_flag;
    logic signed [TC_W-1:0] r10_tcent;

    always_comb begin
        priority if (r9_gt) begin
            n10_hc   = HCENT_MAX;
            n10_flag = FLAG_HIGH;
        end else if (r9_lo) begin
            n10_hc   = HCENT_MIN;
            n10_flag = FLAG_LOW;
        end else begin
            n10_hc   = r9_hc;
            n10_flag = FLAG_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r8_h     <= n8_h;
            r8_tcent <= i_data.tcent;
        end
        if (w_rdy[1]) begin
            r9_gt    <= n9_gt;
            r9_lo    <= n9_lo;
            r9_hc    <= n9_hc;
            r9_tcent <= r8_tcent;
        end
        if (w_rdy[2]) begin
            r10_hc    <= n10_hc;
            r10_flag  <= n10_flag;
            r10_tcent <= r9_tcent;
        end
    end

    assign o_tcent = r10_tcent;
    assign o_hcent = r10_hc;
    assign o_flag  = r10_flag;

endmodule

`default_nettype wire

### rtl/humidity_tick_conversion.sv
// Top level: sensor tick pair to temperature and compensated humidity.
//
//   channel  | direction | transaction holds
//   ---------+-----------+-------------------------------------------------
//   s_axis   | in        | tdata: humidity_ticks, temperature_ticks
//   m_axis   | out       | tdata: temperature_centi, humidity_centi;
//            |           | tuser: clamp_flag
//   cfg      | in        | register index, 40-bit coefficient
//
// Pipeline: one transaction per cycle while m_axis is ready; ten register
//   stages (3 front, 4 for the 56x53 compensation product built from four
//   partial products, 3 for sum, clamp and output).
// Reset: synchronous, active low; clears every stage valid and loads the
//   coefficient defaults. No clearing pass, the block takes input at once.
// Stalls: each stage holds while its successor is full and blocked; empty
//   stages keep filling, so input is taken while a result waits at m_axis.
// Config: cfg ready is always high; write only while the pipeline is empty.
`default_nettype none
`include "humidity_tick_conversion_assert.svh"

module humidity_tick_conversion #(
    parameter int FRAC_BITS = htc_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Sample pair in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [11:0] humidity_ticks, [25:12] temperature_ticks, [31:26] zero
    input  logic [htc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // Result out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [15:0] temperature_centi, [29:16] humidity_centi, [31:30] zero
    output logic [htc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [1:0] clamp_flag
    output logic [htc_pkg::M_TUSER_W-1:0] m_axis_tuser,
    // Coefficient writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [htc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [htc_pkg::REG_W-1:0]     i_cfg_data
);
    import htc_pkg::*;

    localparam int OUT_PAD = M_TDATA_W - TC_W - HC_W;

    t_coef                  w_coef;
    logic                   w_front_vld, w_front_rdy;
    t_front                 w_front_data;
    logic                   w_mid_vld, w_mid_rdy;
    t_mid                   w_mid_data;
    logic signed [TC_W-1:0] w_tcent;
    logic [HC_W-1:0]        w_hcent;
    logic [FLAG_W-1:0]      w_flag;

    // Coefficients; the user keeps them stable while items are in flight, not enforced by the block
    htc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coef      (w_coef)
    );

    // Temperature, linearization and compensation operands
    htc_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (w_coef),
        .i_vld   (s_axis_tvalid),
        .o_rdy   (s_axis_tready),
        .i_rh    (s_axis_tdata[RH_W-1:0]),
        .i_tk    (s_axis_tdata[RH_W +: TK_W]),
        .o_vld   (w_front_vld),
        .i_rdy   (w_front_rdy),
        .o_data  (w_front_data)
    );

    // (T - 25) * factor, floored and saturated
    htc_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_front_vld),
        .o_rdy   (w_front_rdy),
        .i_data  (w_front_data),
        .o_vld   (w_mid_vld),
        .i_rdy   (w_mid_rdy),
        .o_data  (w_mid_data)
    );

    // Add, clamp, round; the last stage is the output register
    htc_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_mid_vld),
        .o_rdy   (w_mid_rdy),
        .i_data  (w_mid_data),
        .o_vld   (m_axis_tvalid),
        .i_rdy   (m_axis_tready),
        .o_tcent (w_tcent),
        .o_hcent (w_hcent),
        .o_flag  (w_flag)
    );

    assign m_axis_tdata = {{OUT_PAD{1'b0}}, w_hcent, w_tcent};
    assign m_axis_tuser = w_flag;

    `HTC_ASSERT_HOLD(a_clamp_high, m_axis_tvalid && (w_flag == FLAG_HIGH), w_hcent == HCENT_MAX, "high clamp without full-scale humidity")
    `HTC_ASSERT_HOLD(a_clamp_low, m_axis_tvalid && (w_flag == FLAG_LOW), w_hcent == HCENT_MIN, "low clamp without minimum humidity")
    `HTC_ASSERT_HOLD(a_in_range, m_axis_tvalid && (w_flag == FLAG_OK), (w_hcent >= HCENT_MIN) && (w_hcent <= HCENT_MAX), "unclamped humidity outside range")

endmodule

`default_nettype wire

### test/tb_humidity_tick_conversion.sv
// Self-checking testbench for the humidity/temperature tick conversion pipeline.
module tb_humidity_tick_conversion;

    import htc_pkg::*;

    // Fixed-point format and run limits
    localparam int     FRAC         = FRAC_BITS_DEF;
    localparam longint FIX_ONE      = longint'(1) << FRAC;
    localparam longint FIX_HALF     = longint'(1) << (FRAC - 1);
    localparam longint MAX64        = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint MIN64        = 64'sh8000_0000_0000_0000;
    localparam int     PIPE_LATENCY = 10;
    localparam int     CYCLE_LIMIT  = 100000;
    localparam int     COEF_COUNT   = 7;
    localparam int     RANDOM_PHASES = 6;
    localparam int     PHASE_ITEMS  = 155;
    localparam int     IDLE_PCT     = 22;

    // Output scale limits of the humidity and temperature readings
    localparam logic [HC_W-1:0] HUM_CEIL_CENTI  = 14'd10000;
    localparam logic [HC_W-1:0] HUM_FLOOR_CENTI = 14'd10;
    localparam longint          TEMP_CEIL_CENTI  = 32767;
    localparam longint          TEMP_FLOOR_CENTI = -32768;

    // First index past the register file; the block drops writes to it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic signed [REG_W-1:0] COEF_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [REG_W-1:0] COEF_MIN = 40'sh80_0000_0000;

    // Coefficients right after reset, Q.32
    localparam t_coef DEFAULT_COEFS = '{
        temp_offset: -40'sd172228188570,
        temp_slope:  40'sd42949673,
        lin_const:   -40'sd8790939061,
        lin_linear:  40'sd157625300,
        lin_square:  -40'sd6853,
        comp_base:   40'sd42949673,
        comp_slope:  40'sd343597
    };

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [TC_W-1:0]   tcent;
        logic [HC_W-1:0]   hcent;
        logic [FLAG_W-1:0] flag;
    } conv_result;

    // DUT ports; every input starts at a known value
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [REG_W-1:0]      i_cfg_data    = '0;

    // Predictor state and bookkeeping
    t_coef       coef_model = DEFAULT_COEFS;
    conv_result  predicted_readings[$];
    conv_result  oldest_reading;
    bit          steady_flow = 1'b0;
    int          fail_count = 0;
    int          samples_sent = 0;
    int          readings_checked = 0;
    int          coef_sets = 1;
    int          flag_hits[4] = '{0, 0, 0, 0};
    int unsigned cycle_count = 0;

    humidity_tick_conversion dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Saturate a wide intermediate to the signed 64-bit range.
    function automatic longint clip64(input wide_t v);
        if (v > wide_t'(MAX64))
            return MAX64;
        if (v < wide_t'(MIN64))
            return MIN64;
        return longint'(v[63:0]);
    endfunction

    // Compute the reading that one sample pair must produce under coef_model.
    function automatic conv_result convert_sample(input logic [RH_W-1:0] rh_ticks,
                                                  input logic [TK_W-1:0] t_ticks);
        conv_result r;
        longint rh, tk, t_fix, scaled, rh_lin, factor, comp, hum;
        rh = rh_ticks;
        tk = t_ticks;

        // Temperature: offset plus slope per tick, then to hundredths, half up
        t_fix  = longint'(coef_model.temp_offset) + longint'(coef_model.temp_slope) * tk;
        scaled = (t_fix * 100 + FIX_HALF) >>> FRAC;
        if (scaled > TEMP_CEIL_CENTI)
            scaled = TEMP_CEIL_CENTI;
        else if (scaled < TEMP_FLOOR_CENTI)
            scaled = TEMP_FLOOR_CENTI;
        r.tcent = scaled[TC_W-1:0];

        // Linearize: square term exact, each sum saturating
        rh_lin = clip64(wide_t'(longint'(coef_model.lin_square) * rh) * wide_t'(rh));
        rh_lin = clip64(wide_t'(rh_lin) + wide_t'(longint'(coef_model.lin_linear) * rh));
        rh_lin = clip64(wide_t'(rh_lin) + wide_t'(longint'(coef_model.lin_const)));

        // Compensate by (T - 25) * factor, product floored back to Q.FRAC
        factor = longint'(coef_model.comp_base) + longint'(coef_model.comp_slope) * rh;
        comp   = clip64((wide_t'(t_fix - 25 * FIX_ONE) * wide_t'(factor)) >>> FRAC);
        hum    = clip64(wide_t'(comp) + wide_t'(rh_lin));

        if (hum > 100 * FIX_ONE) begin
            r.hcent = HUM_CEIL_CENTI;
            r.flag  = FLAG_HIGH;
        end else if (hum < 0 || hum * 10 < FIX_ONE) begin
            r.hcent = HUM_FLOOR_CENTI;
            r.flag  = FLAG_LOW;
        end else begin
            scaled  = (hum * 100 + FIX_HALF) >>> FRAC;
            r.hcent = scaled[HC_W-1:0];
            r.flag  = FLAG_OK;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at cycle %0d, reading %0d, %s: got %0d, expected %0d",
                 cycle_count, readings_checked, what, got, want);
        fail_count++;
    endtask

    // Drop ready at random; hold it high through the steady stretch.
    always @(posedge i_clk) begin
        m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Compare every accepted result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (predicted_readings.size() == 0) begin
                report_mismatch("reading with nothing pending", longint'(m_axis_tdata), 0);
            end else begin
                oldest_reading = predicted_readings.pop_front();
                if (m_axis_tdata[TC_W-1:0] !== oldest_reading.tcent)
                    report_mismatch("temperature_centi",
                                    longint'($signed(m_axis_tdata[TC_W-1:0])),
                                    longint'($signed(oldest_reading.tcent)));
                if (m_axis_tdata[TC_W +: HC_W] !== oldest_reading.hcent)
                    report_mismatch("humidity_centi", longint'(m_axis_tdata[TC_W +: HC_W]),
                                    longint'(oldest_reading.hcent));
                if (m_axis_tdata[M_TDATA_W-1:TC_W+HC_W] !== '0)
                    report_mismatch("tdata padding",
                                    longint'(m_axis_tdata[M_TDATA_W-1:TC_W+HC_W]), 0);
                if (m_axis_tuser[FLAG_W-1:0] !== oldest_reading.flag)
                    report_mismatch("clamp_flag", longint'(m_axis_tuser[FLAG_W-1:0]),
                                    longint'(oldest_reading.flag));
                flag_hits[oldest_reading.flag]++;
                readings_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Offer one sample pair, wait for its transaction, queue the prediction.
    // Valid stays high afterwards so back-to-back samples need no gap.
    task automatic send_sample(input logic [RH_W-1:0] rh_ticks,
                               input logic [TK_W-1:0] t_ticks);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - RH_W - TK_W){1'b0}}, t_ticks, rh_ticks};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted_readings.push_back(convert_sample(rh_ticks, t_ticks));
        samples_sent++;
    endtask

    // Stop sending and wait until every predicted reading has come out.
    task automatic drain_readings();
        s_axis_tvalid <= 1'b0;
        while (predicted_readings.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Write one register and mirror it in the predictor. Valid is left high;
    // the caller drops it once the last write of a batch is through.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_TEMP_OFFSET: coef_model.temp_offset = data;
            REG_TEMP_SLOPE:  coef_model.temp_slope  = data;
            REG_LIN_CONST:   coef_model.lin_const   = data;
            REG_LIN_LINEAR:  coef_model.lin_linear  = data;
            REG_LIN_SQUARE:  coef_model.lin_square  = data;
            REG_COMP_BASE:   coef_model.comp_base   = data;
            REG_COMP_SLOPE:  coef_model.comp_slope  = data;
            default: ;  // index past the register file: the block drops it
        endcase
    endtask

    // Empty the pipeline, then write the whole coefficient set.
    task automatic load_coefs(input t_coef c);
        drain_readings();
        cfg_write(REG_TEMP_OFFSET, c.temp_offset);
        cfg_write(REG_TEMP_SLOPE,  c.temp_slope);
        cfg_write(REG_LIN_CONST,   c.lin_const);
        cfg_write(REG_LIN_LINEAR,  c.lin_linear);
        cfg_write(REG_LIN_SQUARE,  c.lin_square);
        cfg_write(REG_COMP_BASE,   c.comp_base);
        cfg_write(REG_COMP_SLOPE,  c.comp_slope);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        coef_sets++;
    endtask

    // Random coefficient over every magnitude, both signs.
    function automatic logic signed [REG_W-1:0] rand_coef();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return $signed(raw[REG_W-1:0]) >>> $urandom_range(0, REG_W - 1);
    endfunction

    // Move a coefficient by a random fraction of itself, up or down.
    function automatic logic signed [REG_W-1:0] nudge_coef(input logic signed [REG_W-1:0] v);
        logic signed [REG_W-1:0] step;
        step = v >>> $urandom_range(3, 8);
        return $urandom_range(0, 1) ? v + step : v - step;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Coefficients as left by reset: field extremes, alternating bits and a
    // typical room reading. Includes humidity far below zero and far above 100.
    task automatic test_reset_coefs();
        send_sample(12'h000, 14'h0000);
        send_sample(12'hFFF, 14'h3FFF);
        send_sample(12'h000, 14'h3FFF);
        send_sample(12'hFFF, 14'h0000);
        send_sample(12'hAAA, 14'h1555);
        send_sample(12'h555, 14'h2AAA);
        send_sample(12'd1500, 14'd6500);
    endtask

    // Set T - 25 to exactly tk in Q.32 and unit slopes, so humidity lands a
    // few LSBs around the 0.1 percent floor and then around the 100 ceiling.
    task automatic test_humidity_clamps();
        t_coef c;
        c = '0;
        c.temp_offset = 40'sd107374182400;   // 25.0
        c.temp_slope  = 40'sd1;
        c.lin_linear  = 40'sd1;
        c.comp_base   = 40'sd4294967296;     // 1.0
        c.lin_const   = 40'sd429496726;      // a few LSBs under 0.1
        load_coefs(c);
        send_sample(12'd3, 14'd0);           // last value under the floor
        send_sample(12'd0, 14'd4);           // first value at the floor
        c.lin_const   = 40'sd429496729596;   // 100.0 minus four LSBs
        load_coefs(c);
        send_sample(12'd3, 14'd0);           // just under 100
        send_sample(12'd4, 14'd0);           // exactly 100, still in range
        send_sample(12'd0, 14'd5);           // just over 100
    endtask

    // Land both outputs exactly on a half hundredth, positive and (temperature only) negative.
    task automatic test_rounding_halves();
        t_coef c;
        c = '0;
        c.temp_offset = 40'sd536870912;      // 0.125 C
        c.temp_slope  = -40'sd1073741824;    // -0.25 C per tick
        c.lin_const   = 40'sd536870912;      // 0.125 percent
        load_coefs(c);
        send_sample(12'd0, 14'd0);
        send_sample(12'hFFF, 14'd1);
        send_sample(12'h5A5, 14'd2);
    endtask

    // Full-scale coefficients drive both saturation paths; zero is the other extreme.
    task automatic test_coef_extremes();
        load_coefs({COEF_COUNT{COEF_MAX}});
        send_sample(12'hFFF, 14'h3FFF);
        send_sample(12'h000, 14'h0000);
        load_coefs({COEF_COUNT{COEF_MIN}});
        send_sample(12'hFFF, 14'h3FFF);
        send_sample(12'h000, 14'h0000);
        send_sample(12'hFFF, 14'h0000);
        load_coefs('0);
        send_sample(12'h7FF, 14'h2000);
    endtask

    // A write past the last register must leave every coefficient alone.
    task automatic test_unused_index();
        logic [63:0] raw;
        load_coefs(DEFAULT_COEFS);
        raw = {$urandom, $urandom};
        cfg_write(REG_UNUSED, raw[REG_W-1:0]);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_sample(12'd2100, 14'd6600);
        send_sample(12'hFFF, 14'h3FFF);
    endtask

    // Random samples over several coefficient sets: defaults, nudged defaults
    // that keep humidity mostly in range, and wide random values.
    task automatic test_random_traffic();
        t_coef c;
        logic [RH_W-1:0] rh;
        logic [TK_W-1:0] tk;
        int phase, n, k;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            c = DEFAULT_COEFS;
            if (phase % 2 == 1) begin
                for (k = 0; k < COEF_COUNT; k++)
                    c[k*REG_W +: REG_W] = nudge_coef(c[k*REG_W +: REG_W]);
            end else if (phase != 0) begin
                for (k = 0; k < COEF_COUNT; k++)
                    c[k*REG_W +: REG_W] = rand_coef();
            end
            load_coefs(c);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Long stretch with neither side idling
                steady_flow = (phase == 0 && n >= 30 && n < 130);
                // Pause the sender until the pipeline has fully emptied
                if (phase == 1 && n == PHASE_ITEMS / 2)
                    drain_readings();
                rh = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 12'hFFF : 12'h000)
                                                 : RH_W'($urandom_range(0, 4095));
                tk = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 14'h3FFF : 14'h0000)
                                                 : TK_W'($urandom_range(0, 16383));
                send_sample(rh, tk);
            end
        end
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_coefs();
        test_humidity_clamps();
        test_rounding_halves();
        test_coef_extremes();
        test_unused_index();
        test_random_traffic();

        // Let the last results out, then watch for strays
        drain_readings();
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);

        $display("Sent %0d sample pairs under %0d coefficient sets; %0d readings checked",
                 samples_sent, coef_sets, readings_checked);
        $display("Humidity outcomes: %0d in range, %0d held at 100, %0d held at 0.1",
                 flag_hits[FLAG_OK], flag_hits[FLAG_HIGH], flag_hits[FLAG_LOW]);
        if (fail_count == 0)
            $display("tb_humidity_tick_conversion: done, clean");
        else
            $display("tb_humidity_tick_conversion: done, errors");
        $finish;
    end

    // Give up when the run takes far longer than any correct run could.
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("Timeout after %0d cycles, %0d readings still pending",
                 cycle_count, predicted_readings.size());
        $display("tb_humidity_tick_conversion: done, errors");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/htc_pkg.sv
rtl/htc_cfg.sv
rtl/htc_front.sv
rtl/htc_mul.sv
rtl/htc_out.sv
rtl/humidity_tick_conversion.sv
test/tb_humidity_tick_conversion.sv
